// ===== rtl/core/kwm_pkg.sv =====
// kwm_pkg: shared types, codes and field widths of the k-way merge heap
package kwm_pkg;

  // field widths of the input and result beats
  localparam int ACTION_W  = 2;
  localparam int LIST_ID_W = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  typedef logic        [ACTION_W-1:0]  action_t;
  typedef logic        [LIST_ID_W-1:0] list_id_t;
  typedef logic signed [VALUE_W-1:0]   value_t;
  typedef logic        [STATUS_W-1:0]  status_t;

  // action codes
  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_POP   = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  // status codes
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_POPPED    = 2'd1;
  localparam status_t STAT_EXHAUSTED = 2'd2;
  localparam status_t STAT_REJECTED  = 2'd3;

  // ordering key of a heap node: an exhausted node ranks above every value
  typedef struct packed {
    logic   done;
    value_t val;
  } cmp_key_t;

endpackage

// ===== rtl/core/kwm_ram.sv =====
// kwm_ram: generic single-write, single-read ram with registered read data
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kwm_cmp.sv =====
// kwm_cmp: shared node comparator, true when node a ranks strictly below node b
module kwm_cmp (
  input  kwm_pkg::cmp_key_t a,
  input  kwm_pkg::cmp_key_t b,
  output logic              less
);
  import kwm_pkg::*;

  // exhausted nodes never win, any live node beats an exhausted one
  always_comb begin
    if (a.done) begin
      less = 1'b0;
    end else if (b.done) begin
      less = 1'b1;
    end else begin
      less = $signed(a.val) < $signed(b.val);
    end
  end

endmodule

// ===== rtl/core/k_way_merge_heap.sv =====
// k_way_merge_heap: k-way merge of ascending lists through a min heap, one node per list
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   input   | in        | in_valid / in_stall | action, list_id, value
//   result  | out       | out_valid/out_stall | status, merged_value
//
// one item at a time; in_stall is high from acceptance until the result is in the
// output register. load, clear and ignored actions go straight to the result;
// a pop checks the root, refills it from its own list if that list has more,
// then sifts down through a left child, right child and swap step per heap level;
// the first pop also builds the heap from the list heads, then sifts every inner node.
// reset and clear empty all lists; list storage is not cleared.
// a result held by out_stall does not block the next input beat.
module k_way_merge_heap #(
  parameter int LISTS      = 5,
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  kwm_pkg::action_t  action,
  input  kwm_pkg::list_id_t list_id,
  input  kwm_pkg::value_t   value,
  output logic              out_valid,
  input  logic              out_stall,
  output kwm_pkg::status_t  status,
  output kwm_pkg::value_t   merged_value
);
  import kwm_pkg::*;

  localparam int IW         = $clog2(LISTS);
  localparam int PW         = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = LISTS * LIST_DEPTH;
  localparam int EW         = $clog2(MEM_DEPTH);
  localparam int CW         = IW + 2;
  localparam int BUILD_ROOT = (LISTS - 1) / 2;

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_BUILD_FILL = 4'd1;
  localparam logic [3:0] S_BUILD_WAIT = 4'd2;
  localparam logic [3:0] S_POP_CHECK  = 4'd3;
  localparam logic [3:0] S_POP_WAIT   = 4'd4;
  localparam logic [3:0] S_SIFT_START = 4'd5;
  localparam logic [3:0] S_SIFT_L     = 4'd6;
  localparam logic [3:0] S_SIFT_R     = 4'd7;
  localparam logic [3:0] S_SIFT_SWAP  = 4'd8;
  localparam logic [3:0] S_EMIT       = 4'd9;

  typedef struct packed {
    logic          done;
    logic [IW-1:0] src;
    value_t        val;
  } node_t;

  logic [3:0]    state;
  action_t       cmd_action;
  status_t       res_status;
  value_t        res_value;
  logic          started;
  logic          building;
  logic [PW-1:0] len [LISTS];
  logic [PW-1:0] rp [LISTS];
  node_t         heap [LISTS];
  logic [IW-1:0] cnt;
  logic [IW-1:0] pos;
  logic [IW-1:0] bidx;
  node_t         hold;
  node_t         best;

  logic          id_ok;
  logic          load_ok;
  logic [IW-1:0] sel;
  logic [PW-1:0] sel_len;
  logic [PW-1:0] sel_rp;
  node_t         root;
  logic [CW-1:0] lc;
  logic [CW-1:0] rc;
  logic          lc_ok;
  logic          rc_ok;
  logic [IW-1:0] rd_idx;
  node_t         heap_rd;
  cmp_key_t      key_a;
  cmp_key_t      key_b;
  logic          less;
  logic          ram_we;
  logic [EW-1:0] ram_waddr;
  logic [EW-1:0] ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // flat address of an element in the shared list store
  function automatic logic [EW-1:0] elem_addr(input logic [IW-1:0] idx,
                                              input logic [PW-1:0] ptr);
    elem_addr = EW'(idx) * EW'(LIST_DEPTH) + EW'(ptr);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign root     = heap[0];
  assign id_ok    = int'(list_id) < LISTS;

  // one list index per cycle for length and read pointer lookups
  always_comb begin
    unique case (state)
      S_IDLE:       sel = id_ok ? IW'(list_id) : '0;
      S_BUILD_FILL: sel = cnt;
      default:      sel = root.src;
    endcase
  end

  assign sel_len = len[sel];
  assign sel_rp  = rp[sel];
  assign load_ok = !started && id_ok && (sel_len < PW'(LIST_DEPTH));

  // children of the sift position
  assign lc    = {1'b0, pos, 1'b1};
  assign rc    = {1'b0, pos, 1'b0} + CW'(2);
  assign lc_ok = lc < CW'(LISTS);
  assign rc_ok = rc < CW'(LISTS);

  // single heap read port for the sift
  always_comb begin
    unique case (state)
      S_SIFT_L: rd_idx = lc[IW-1:0];
      S_SIFT_R: rd_idx = rc[IW-1:0];
      default:  rd_idx = pos;
    endcase
  end

  assign heap_rd = (int'(rd_idx) < LISTS) ? heap[rd_idx] : '0;

  // shared comparator: candidate child against best so far
  assign key_a = '{done: heap_rd.done, val: heap_rd.val};
  assign key_b = '{done: best.done, val: best.val};

  kwm_cmp u_cmp (
    .a    (key_a),
    .b    (key_b),
    .less (less)
  );

  // list store: loads write, build and refill read
  assign ram_we    = (state == S_IDLE) && in_valid && (action == ACT_LOAD) && load_ok;
  assign ram_waddr = elem_addr(sel, sel_len);
  assign ram_raddr = (state == S_BUILD_FILL) ? elem_addr(cnt, '0) : elem_addr(sel, sel_rp);

  kwm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      building  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        len[i] <= '0;
        rp[i]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_action <= action;
            res_value  <= '0;
            res_status <= STAT_REJECTED;
            state      <= S_EMIT;
            unique case (action)
              ACT_LOAD: begin
                if (load_ok) begin
                  len[sel]   <= sel_len + PW'(1);
                  res_status <= STAT_OK;
                end
              end
              ACT_POP: begin
                if (started) begin
                  state <= S_POP_CHECK;
                end else begin
                  cnt      <= '0;
                  building <= 1'b1;
                  state    <= S_BUILD_FILL;
                end
              end
              ACT_CLEAR: begin
                for (int i = 0; i < LISTS; i++) begin
                  len[i] <= '0;
                  rp[i]  <= '0;
                end
                started    <= 1'b0;
                res_status <= STAT_OK;
              end
              default: ;
            endcase
          end
        end
        // load every node from the head of its list
        S_BUILD_FILL: begin
          heap[cnt].src <= cnt;
          if (sel_len != '0) begin
            rp[cnt] <= PW'(1);
            state   <= S_BUILD_WAIT;
          end else begin
            rp[cnt]        <= '0;
            heap[cnt].done <= 1'b1;
            heap[cnt].val  <= '0;
            if (cnt == IW'(LISTS - 1)) begin
              cnt   <= IW'(BUILD_ROOT);
              pos   <= IW'(BUILD_ROOT);
              state <= S_SIFT_START;
            end else begin
              cnt <= cnt + IW'(1);
            end
          end
        end
        S_BUILD_WAIT: begin
          heap[cnt].val  <= ram_rdata;
          heap[cnt].done <= 1'b0;
          if (cnt == IW'(LISTS - 1)) begin
            cnt   <= IW'(BUILD_ROOT);
            pos   <= IW'(BUILD_ROOT);
            state <= S_SIFT_START;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_BUILD_FILL;
          end
        end
        // take the root and refill it from its own list
        S_POP_CHECK: begin
          if (root.done) begin
            res_status <= STAT_EXHAUSTED;
            state      <= S_EMIT;
          end else begin
            res_value  <= root.val;
            res_status <= STAT_POPPED;
            pos        <= '0;
            if (sel_rp < sel_len) begin
              rp[sel] <= sel_rp + PW'(1);
              state   <= S_POP_WAIT;
            end else begin
              heap[0].done <= 1'b1;
              heap[0].val  <= '0;
              state        <= S_SIFT_START;
            end
          end
        end
        S_POP_WAIT: begin
          heap[0].val  <= ram_rdata;
          heap[0].done <= 1'b0;
          state        <= S_SIFT_START;
        end
        // sift down, one comparison at a time: left child, then right child, then swap
        S_SIFT_START: begin
          hold  <= heap_rd;
          best  <= heap_rd;
          bidx  <= pos;
          state <= S_SIFT_L;
        end
        S_SIFT_L: begin
          if (lc_ok && less) begin
            best <= heap_rd;
            bidx <= lc[IW-1:0];
          end
          state <= S_SIFT_R;
        end
        S_SIFT_R: begin
          if (rc_ok && less) begin
            best <= heap_rd;
            bidx <= rc[IW-1:0];
          end
          state <= S_SIFT_SWAP;
        end
        S_SIFT_SWAP: begin
          if (bidx == pos) begin
            heap[pos] <= hold;
            if (building) begin
              if (cnt == '0) begin
                building <= 1'b0;
                started  <= 1'b1;
                state    <= S_POP_CHECK;
              end else begin
                cnt   <= cnt - IW'(1);
                pos   <= cnt - IW'(1);
                state <= S_SIFT_START;
              end
            end else begin
              state <= S_EMIT;
            end
          end else begin
            heap[pos] <= best;
            best      <= hold;
            pos       <= bidx;
            state     <= S_SIFT_L;
          end
        end
        // hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            merged_value <= res_value;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a pop always answers from a built heap
  a_pop_after_build: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && (cmd_action == ACT_POP) |-> started)
    else $error("pop result without a built heap");

  // only a popped beat carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_POPPED) |-> (merged_value == '0))
    else $error("non-pop result carries a value");

  // busy after every accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  for (genvar g = 0; g < LISTS; g++) begin : g_chk
    // read pointer never passes the list length
    a_rp_bound: assert property (@(posedge clk) disable iff (rst)
      rp[g] <= len[g])
      else $error("read pointer beyond list length");

    // an exhausted root means every node is exhausted
    a_root_min: assert property (@(posedge clk) disable iff (rst)
      started && (state == S_IDLE) && heap[0].done |-> heap[g].done)
      else $error("exhausted root over a live node");
  end

endmodule

// ===== test/k_way_merge_heap_tb.sv =====
// k_way_merge_heap_tb: self-checking testbench of the k-way merge heap, with its own merge predictor
`timescale 1ns / 100ps

module k_way_merge_heap_tb;
  import kwm_pkg::*;

  localparam int LISTS       = 5;
  localparam int LIST_DEPTH  = 16;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int VAL_MAX     = 2147483647;
  localparam int VAL_MIN     = -2147483647 - 1;

  // the one action code with no meaning
  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic       done;
    logic [2:0] src;
    value_t     val;
  } node_t;

  typedef struct packed {
    status_t st;
    value_t  mv;
  } merge_out_t;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      in_valid     = 1'b0;
  logic      in_stall;
  action_t   action       = ACT_CLEAR;
  list_id_t  list_id      = '0;
  value_t    value        = '0;
  logic      out_valid;
  logic      out_stall    = 1'b0;
  status_t   status;
  value_t    merged_value;

  // predictor state
  value_t list_mem [LISTS][LIST_DEPTH];
  int     list_fill [LISTS];
  int     list_rd [LISTS];
  node_t  heap [LISTS];
  bit     merging = 1'b0;

  merge_out_t merge_expect_q[$];

  int mismatch_count  = 0;
  int beats_sent      = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req_cnt    = 0;
  int hold_seen_cnt   = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  k_way_merge_heap #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .list_id      (list_id),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .merged_value (merged_value)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // heap ordering: an exhausted node never wins, ties keep the parent
  function automatic bit ranks_below(input node_t a, input node_t b);
    if (a.done) return 1'b0;
    if (b.done) return 1'b1;
    return a.val < b.val;
  endfunction

  function automatic void sift_from(input int start);
    int    pos;
    int    l;
    int    r;
    int    s;
    bit    moving;
    node_t t;
    pos = start;
    moving = 1'b1;
    while (moving) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      s = pos;
      if (l < LISTS && ranks_below(heap[l], heap[s])) s = l;
      if (r < LISTS && ranks_below(heap[r], heap[s])) s = r;
      if (s == pos) begin
        moving = 1'b0;
      end else begin
        t = heap[pos];
        heap[pos] = heap[s];
        heap[s] = t;
        pos = s;
      end
    end
  endfunction

  // take the next element of a list into a node, or mark it exhausted
  function automatic void refill_node(input int slot, input int lst);
    heap[slot].src = lst[2:0];
    if (list_rd[lst] < list_fill[lst]) begin
      heap[slot].val  = list_mem[lst][list_rd[lst]];
      heap[slot].done = 1'b0;
      list_rd[lst]++;
    end else begin
      heap[slot].val  = '0;
      heap[slot].done = 1'b1;
    end
  endfunction

  function automatic void merge_predict(input action_t act, input list_id_t lid,
                                        input value_t v, output merge_out_t res);
    int i;
    res.st = STAT_REJECTED;
    res.mv = '0;
    case (act)
      ACT_LOAD: begin
        if (!merging && lid < LISTS && list_fill[lid] < LIST_DEPTH) begin
          list_mem[lid][list_fill[lid]] = v;
          list_fill[lid]++;
          res.st = STAT_OK;
        end
      end
      ACT_POP: begin
        // first pop builds the heap from every list head
        if (!merging) begin
          for (i = 0; i < LISTS; i++) begin
            list_rd[i] = 0;
            refill_node(i, i);
          end
          for (i = (LISTS - 1) / 2; i >= 0; i--) sift_from(i);
          merging = 1'b1;
        end
        if (heap[0].done) begin
          res.st = STAT_EXHAUSTED;
        end else begin
          res.mv = heap[0].val;
          res.st = STAT_POPPED;
          refill_node(0, heap[0].src);
          sift_from(0);
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < LISTS; i++) begin
          list_fill[i] = 0;
          list_rd[i]   = 0;
        end
        merging = 1'b0;
        res.st = STAT_OK;
      end
      default: ;
    endcase
  endfunction

  // offer one beat, wait for it to be taken, then predict its result
  task automatic send_beat(input action_t act, input list_id_t lid, input value_t v);
    merge_out_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    list_id  <= lid;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    merge_predict(act, lid, v, res);
    merge_expect_q.push_back(res);
    beats_sent++;
  endtask

  // sender pauses until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (merge_expect_q.size() != 0);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_beat(ACT_UNUSED, list_id_t'($urandom_range(7)), value_t'($urandom));
      1: send_beat(ACT_LOAD, list_id_t'($urandom_range(7, LISTS)), value_t'($urandom));
      default: send_beat(ACT_LOAD, list_id_t'($urandom_range(LISTS - 1)), value_t'($urandom));
    endcase
  endtask

  // extremes, ties, bad list numbers, unused action, late loads
  task automatic test_directed();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_beat(ACT_POP, 3'd0, 32'sd0);
    send_beat(ACT_POP, 3'd7, 32'sd0);
    send_beat(ACT_LOAD, 3'd0, 32'sd5);
    send_beat(ACT_UNUSED, 3'd0, 32'sd0);
    send_beat(ACT_CLEAR, 3'd0, 32'sd0);
    send_beat(ACT_LOAD, 3'd0, value_t'(VAL_MIN));
    send_beat(ACT_LOAD, 3'd0, -32'sd1);
    send_beat(ACT_LOAD, 3'd1, 32'sd0);
    send_beat(ACT_LOAD, 3'd1, value_t'(VAL_MAX));
    send_beat(ACT_LOAD, 3'd2, -32'sd1);
    send_beat(ACT_LOAD, 3'd3, 32'sd7);
    send_beat(ACT_LOAD, 3'd4, value_t'(VAL_MAX));
    send_beat(ACT_LOAD, 3'd5, 32'sd1);
    send_beat(ACT_LOAD, 3'd7, value_t'(32'hAAAA_AAAA));
    send_beat(ACT_UNUSED, 3'd6, value_t'(32'h5555_5555));
    for (k = 0; k < 8; k++) send_beat(ACT_POP, 3'd0, 32'sd0);
    send_beat(ACT_LOAD, 3'd0, 32'sd1);
    send_beat(ACT_CLEAR, 3'd7, value_t'(32'hFFFF_FFFF));
  endtask

  // one list loaded past its depth, then merged out
  task automatic test_full_list();
    int k;
    send_beat(ACT_CLEAR, 3'd0, 32'sd0);
    for (k = 0; k <= LIST_DEPTH; k++) send_beat(ACT_LOAD, 3'd3, value_t'(k * 1000 - 8000));
    send_beat(ACT_LOAD, 3'd0, 32'sd500);
    for (k = 0; k < LIST_DEPTH + 2; k++) send_beat(ACT_POP, 3'd0, 32'sd0);
    drain();
  endtask

  // long receiver hold while the sender keeps offering beats
  task automatic test_backpressure();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_beat(ACT_CLEAR, 3'd0, 32'sd0);
    for (k = 0; k < 12; k++) send_beat(ACT_LOAD, list_id_t'(k % LISTS), value_t'(k * 3 - 10));
    hold_req_cnt <= hold_req_cnt + 1;
    for (k = 0; k < 15; k++) send_beat(ACT_POP, 3'd0, 32'sd0);
    drain();
  endtask

  // clear, interleaved ascending loads with some noise, then pops past the end
  task automatic merge_round();
    int     left [LISTS];
    longint cur [LISTS];
    int     step_max [LISTS];
    int     l;
    int     k;
    int     remaining;
    int     n_pops;
    longint nxt;
    value_t v;
    send_beat(ACT_CLEAR, list_id_t'($urandom_range(7)), value_t'($urandom));
    remaining = 0;
    for (l = 0; l < LISTS; l++) begin
      case ($urandom_range(9))
        0: left[l] = 0;
        1: left[l] = LIST_DEPTH + 1;
        2, 3: left[l] = $urandom_range(LIST_DEPTH);
        default: left[l] = $urandom_range(5, 1);
      endcase
      remaining += left[l];
      case ($urandom_range(3))
        0: begin
          cur[l] = longint'(VAL_MIN) + $urandom_range(3);
          step_max[l] = 3;
        end
        1: begin
          cur[l] = longint'($urandom_range(8)) - 4;
          step_max[l] = 2;
        end
        2: begin
          cur[l] = longint'($signed($urandom));
          step_max[l] = 32'h0FFF_FFFF;
        end
        default: begin
          cur[l] = longint'(VAL_MAX) - $urandom_range(20);
          step_max[l] = 4;
        end
      endcase
    end
    // loads, lists picked at random
    while (remaining > 0) begin
      l = $urandom_range(LISTS - 1);
      if (left[l] > 0) begin
        if ($urandom_range(99) < 6) send_noise();
        if ($urandom_range(99) < 3) v = value_t'($urandom);
        else v = value_t'(cur[l]);
        send_beat(ACT_LOAD, list_id_t'(l), v);
        nxt = cur[l] + $urandom_range(step_max[l]);
        if (nxt > VAL_MAX) nxt = VAL_MAX;
        cur[l] = nxt;
        left[l]--;
        remaining--;
      end
    end
    // pops, with rejected loads and the odd early clear
    n_pops = LISTS * LIST_DEPTH + 3;
    for (k = 0; k < n_pops; k++) begin
      if ($urandom_range(99) < 5) send_noise();
      if ($urandom_range(199) == 0) begin
        send_beat(ACT_CLEAR, list_id_t'($urandom_range(7)), value_t'($urandom));
        k = n_pops;
      end else begin
        send_beat(ACT_POP, list_id_t'($urandom_range(7)), value_t'($urandom));
        if (status_exhausted_pending()) k = n_pops - $urandom_range(2);
      end
    end
    if ($urandom_range(99) < 30) drain();
  endtask

  // the newest prediction says every list has run dry
  function automatic bit status_exhausted_pending();
    if (merge_expect_q.size() == 0) return 1'b0;
    return merge_expect_q[merge_expect_q.size() - 1].st == STAT_EXHAUSTED;
  endfunction

  task automatic test_random_merge(input int idle_pct, input int stall_pct, input int n_beats);
    int stop_at;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) merge_round();
  endtask

  // receiver stall: random, or a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    merge_out_t exp_out;
    if (!rst && out_valid && !out_stall) begin
      if (merge_expect_q.size() == 0) begin
        $error("unexpected result beat: status %0d, merged_value %0d", status, merged_value);
        mismatch_count++;
      end else begin
        exp_out = merge_expect_q.pop_front();
        if (status !== exp_out.st) begin
          $error("status: expected %0d, got %0d", exp_out.st, status);
          mismatch_count++;
        end
        if (merged_value !== exp_out.mv) begin
          $error("merged_value: expected %0d, got %0d", exp_out.mv, merged_value);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_list();
    test_backpressure();
    test_random_merge(0, 0, 240);
    test_random_merge(77, 0, 240);
    test_random_merge(0, 77, 240);
    test_random_merge(35, 35, 240);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && merge_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/kwm_cmp.sv
rtl/core/k_way_merge_heap.sv
test/k_way_merge_heap_tb.sv
